// ===== design/pstm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pstm_pkg;

  localparam int VIDX_W       = 4;
  localparam int IN_WEIGHT_W  = 16;
  localparam int OUT_WEIGHT_W = 16;
  localparam int TOTAL_W      = 20;
  localparam int VCOUNT_W     = 5;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

  typedef struct packed {
    logic [VIDX_W-1:0]      row;
    logic [VIDX_W-1:0]      column;
    logic [IN_WEIGHT_W-1:0] weight;
    logic                   last;
  } in_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0]       parent_vertex;
    logic [VIDX_W-1:0]       child_vertex;
    logic [OUT_WEIGHT_W-1:0] edge_weight;
    logic                    reached;
    logic [TOTAL_W-1:0]      total_cost;
    logic                    last_edge;
  } out_item_t;

  // sequencer -> cell controls
  typedef struct packed {
    logic init;   // start of run: keys, parents, tree flags back to reset values
    logic mark;   // add the current vertex to the tree
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/pstm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pstm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/pstm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One vertex: key, parent, tree flag. A search token passes through once per
// round; the cell relaxes against the broadcast row weight, then offers its key.
module pstm_cell #(
  parameter int IDX = 0,
  parameter int VW  = 4,
  parameter int NW  = 5,
  parameter int WB  = 16,
  localparam int KW = WB + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pstm_pkg::cell_ctl_t  ctl,
  input  wire logic [VW-1:0]        u_vertex,
  input  wire logic [NW-1:0]        n_used,
  input  wire logic [WB-1:0]        row_weight,
  input  wire logic                 tok_in_valid,
  input  wire logic [KW-1:0]        tok_in_low,
  input  wire logic [VW-1:0]        tok_in_best,
  output logic                      tok_out_valid,
  output logic      [KW-1:0]        tok_out_low,
  output logic      [VW-1:0]        tok_out_best,
  output logic      [KW-1:0]        key,
  output logic      [VW-1:0]        parent
);

  localparam logic [KW-1:0] KEY_INF  = {1'b1, {WB{1'b0}}};
  localparam logic [KW-1:0] KEY_INIT = (IDX == 0) ? '0 : KEY_INF;
  localparam logic [VW-1:0] MY_IDX   = VW'(IDX);

  logic [KW-1:0] key_r, key_nxt;
  logic [VW-1:0] parent_r, parent_nxt;
  logic          in_tree_r, in_tree_nxt;
  logic          tok_valid_r;
  logic [KW-1:0] tok_low_r, tok_low_nxt;
  logic [VW-1:0] tok_best_r, tok_best_nxt;
  logic          active, relax, cand;
  logic [KW-1:0] new_key;

  assign active  = (NW'(IDX) < n_used);
  assign relax   = tok_in_valid && active && !in_tree_r && (row_weight != '0) &&
                   ({1'b0, row_weight} < key_r);
  assign new_key = relax ? {1'b0, row_weight} : key_r;
  // strict compare: earlier (lower) vertex wins a tie
  assign cand    = tok_in_valid && active && !in_tree_r && (new_key < tok_in_low);

  always_comb begin
    key_nxt     = key_r;
    parent_nxt  = parent_r;
    in_tree_nxt = in_tree_r;
    if (ctl.init) begin
      key_nxt     = KEY_INIT;
      parent_nxt  = '0;
      in_tree_nxt = 1'b0;
    end else begin
      if (ctl.mark && (u_vertex == MY_IDX)) begin
        in_tree_nxt = 1'b1;
      end
      if (relax) begin
        key_nxt    = new_key;
        parent_nxt = u_vertex;
      end
    end
    tok_low_nxt  = cand ? new_key : tok_in_low;
    tok_best_nxt = cand ? MY_IDX : tok_in_best;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= KEY_INIT;
      parent_r    <= '0;
      in_tree_r   <= 1'b0;
      tok_valid_r <= 1'b0;
    end else begin
      key_r       <= key_nxt;
      parent_r    <= parent_nxt;
      in_tree_r   <= in_tree_nxt;
      tok_valid_r <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_low_r  <= tok_low_nxt;
    tok_best_r <= tok_best_nxt;
  end

  assign tok_out_valid = tok_valid_r;
  assign tok_out_low   = tok_low_r;
  assign tok_out_best  = tok_best_r;
  assign key           = key_r;
  assign parent        = parent_r;

endmodule

`default_nettype wire

// ===== design/prim_spanning_tree_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Flow: matrix entries load at one request per cycle while in_ready is high. A request with
//   last set starts a run of one round per vertex added (at most n-1), each round the
//   search token walking the cell chain once; then n-1 results leave at one per cycle while
//   out_ready is high. No input is taken during a run.
// Reset (rst_n low, synchronous): control, cells and vertex_count (16) reset;
//   the weight store keeps no reset value and gets no clearing pass.
module prim_spanning_tree_matrix #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire pstm_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output pstm_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [pstm_pkg::VCOUNT_W-1:0]    cfg_wdata
);

  localparam int VW    = $clog2(MAX_VERTICES);        // vertex index
  localparam int NW    = $clog2(MAX_VERTICES + 1);    // vertex count
  localparam int KW    = WEIGHT_BITS + 1;             // key, top bit = infinite
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = pstm_pkg::VIDX_W;
  localparam int EW    = pstm_pkg::OUT_WEIGHT_W;
  localparam int TW    = pstm_pkg::TOTAL_W;
  localparam int CW    = pstm_pkg::VCOUNT_W;

  localparam logic [KW-1:0] KEY_INF    = {1'b1, {WEIGHT_BITS{1'b0}}};
  localparam logic [NW-1:0] N_MAX      = NW'(MAX_VERTICES);
  localparam logic [NW-1:0] N_MIN      = NW'(2);
  localparam logic [VW-1:0] COL_LAST   = VW'(MAX_VERTICES - 1);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_VERTICES);

  // sequencer states
  localparam logic [2:0] S_LOAD  = 3'd0;   // taking matrix entries
  localparam logic [2:0] S_INIT  = 3'd1;   // reset cells for a new run
  localparam logic [2:0] S_MARK  = 3'd2;   // add vertex u, start reading row u
  localparam logic [2:0] S_ROUND = 3'd3;   // token walks the chain
  localparam logic [2:0] S_OUT   = 3'd4;   // report vertices 1 .. n-1

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] vcount_r;
  logic [VW-1:0] u_r, u_nxt;
  logic [VW-1:0] picks_r, picks_nxt;        // vertices added this run
  logic [VW-1:0] col_r, col_nxt;
  logic          tok_inject_r;
  logic [NW-1:0] ov_r, ov_nxt;              // vertex being reported
  logic [TW-1:0] total_r, total_nxt;
  logic          out_valid_r, out_valid_nxt;
  pstm_pkg::out_item_t out_data_r, out_data_nxt;

  logic [NW-1:0] n_used;
  pstm_pkg::cell_ctl_t ctl;

  // ---- vertex count, saturated into 2 .. MAX_VERTICES
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= pstm_pkg::VCOUNT_RESET;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (int'(vcount_r) < 2) begin
      n_used = N_MIN;
    end else if (int'(vcount_r) > MAX_VERTICES) begin
      n_used = N_MAX;
    end else begin
      n_used = NW'(vcount_r);
    end
  end

  // ---- weight store: written on every accepted request in range,
  //      read one row entry per cycle during a round
  logic                   in_fire, wr_in_range, ram_we;
  logic [AW-1:0]          waddr, raddr;
  logic [VW-1:0]          col_sel;
  logic [WEIGHT_BITS-1:0] row_weight;

  assign in_ready    = (state_r == S_LOAD);
  assign in_fire     = in_valid && in_ready;
  assign wr_in_range = (int'(in_data.row) < MAX_VERTICES) &&
                       (int'(in_data.column) < MAX_VERTICES);
  assign ram_we      = in_fire && wr_in_range;
  assign waddr       = AW'(in_data.row) * ROW_STRIDE + AW'(in_data.column);
  assign col_sel     = (state_r == S_MARK) ? '0 : col_r;
  assign raddr       = AW'(u_r) * ROW_STRIDE + AW'(col_sel);

  pstm_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (WEIGHT_BITS'(in_data.weight)),
    .raddr (raddr),
    .rdata (row_weight)
  );

  // ---- cell chain. The token enters cell 0 with the data for column 0 and
  //      moves one cell per cycle, in step with the row read, so each cell sees
  //      its own entry of row u on the broadcast bus. It leaves carrying the
  //      smallest key outside the tree and its vertex.
  logic [MAX_VERTICES-1:0] tok_valid_vec;
  logic [KW-1:0]           tok_low_arr  [MAX_VERTICES];
  logic [VW-1:0]           tok_best_arr [MAX_VERTICES];
  logic [KW-1:0]           cell_key     [MAX_VERTICES];
  logic [VW-1:0]           cell_parent  [MAX_VERTICES];

  for (genvar gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
    logic          tin_valid;
    logic [KW-1:0] tin_low;
    logic [VW-1:0] tin_best;

    if (gi == 0) begin : g_head
      assign tin_valid = tok_inject_r;
      assign tin_low   = KEY_INF;
      assign tin_best  = '0;
    end else begin : g_link
      assign tin_valid = tok_valid_vec[gi-1];
      assign tin_low   = tok_low_arr[gi-1];
      assign tin_best  = tok_best_arr[gi-1];
    end

    pstm_cell #(
      .IDX (gi),
      .VW  (VW),
      .NW  (NW),
      .WB  (WEIGHT_BITS)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .u_vertex      (u_r),
      .n_used        (n_used),
      .row_weight    (row_weight),
      .tok_in_valid  (tin_valid),
      .tok_in_low    (tin_low),
      .tok_in_best   (tin_best),
      .tok_out_valid (tok_valid_vec[gi]),
      .tok_out_low   (tok_low_arr[gi]),
      .tok_out_best  (tok_best_arr[gi]),
      .key           (cell_key[gi]),
      .parent        (cell_parent[gi])
    );
  end

  // ---- sequencer
  logic          tok_done, found, picks_done, out_load;
  logic [KW-1:0] sel_key;
  logic [VW-1:0] sel_parent;
  logic          sel_reached;
  logic [EW-1:0] sel_weight;

  assign tok_done   = tok_valid_vec[MAX_VERTICES-1];
  assign found      = (tok_low_arr[MAX_VERTICES-1] != KEY_INF);
  assign picks_done = (NW'(picks_r) == (n_used - NW'(1)));

  assign out_load    = (state_r == S_OUT) && (ov_r != n_used) &&
                       (!out_valid_r || out_ready);
  assign sel_key     = cell_key[ov_r[VW-1:0]];
  assign sel_parent  = cell_parent[ov_r[VW-1:0]];
  assign sel_reached = !sel_key[WEIGHT_BITS];
  assign sel_weight  = sel_reached ? EW'(sel_key[WEIGHT_BITS-1:0]) : '0;

  always_comb begin
    state_nxt     = state_r;
    u_nxt         = u_r;
    picks_nxt     = picks_r;
    col_nxt       = col_r;
    ov_nxt        = ov_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctl           = '0;

    unique case (state_r)
      S_LOAD: begin
        if (in_fire && in_data.last) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        ctl.init  = 1'b1;
        u_nxt     = '0;       // vertex 0 starts with key zero, always picked first
        picks_nxt = '0;
        state_nxt = S_MARK;
      end
      S_MARK: begin
        ctl.mark  = 1'b1;
        picks_nxt = picks_r + 1'b1;
        col_nxt   = VW'(1);
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        if (col_r != COL_LAST) begin
          col_nxt = col_r + 1'b1;
        end
        if (tok_done) begin
          // all picks done, or disconnected graph: nothing finite left, stop early
          if (picks_done || !found) begin
            ov_nxt    = NW'(1);
            total_nxt = '0;
            state_nxt = S_OUT;
          end else begin
            u_nxt     = tok_best_arr[MAX_VERTICES-1];
            state_nxt = S_MARK;
          end
        end
      end
      S_OUT: begin
        if (ov_r == n_used) begin
          state_nxt = S_LOAD;
        end else if (out_load) begin
          total_nxt                  = total_r + TW'(sel_weight);
          out_valid_nxt              = 1'b1;
          out_data_nxt.parent_vertex = sel_reached ? PW'(sel_parent) : '0;
          out_data_nxt.child_vertex  = PW'(ov_r);
          out_data_nxt.edge_weight   = sel_weight;
          out_data_nxt.reached       = sel_reached;
          out_data_nxt.total_cost    = total_r + TW'(sel_weight);
          out_data_nxt.last_edge     = (ov_r == (n_used - NW'(1)));
          ov_nxt                     = ov_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      u_r          <= '0;
      picks_r      <= '0;
      col_r        <= '0;
      tok_inject_r <= 1'b0;
      ov_r         <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      u_r          <= u_nxt;
      picks_r      <= picks_nxt;
      col_r        <= col_nxt;
      tok_inject_r <= (state_r == S_MARK);
      ov_r         <= ov_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- checks
  // at most one search token in flight
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({tok_inject_r, tok_valid_vec}) <= 1)
    else $error("more than one search token in the cell chain");

  // loading only while the chain is empty
  a_idle_chain: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> ((tok_valid_vec == '0) && !tok_inject_r))
    else $error("request taken while a search is running");

  // rounds never add more than n-1 vertices
  a_picks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> ((NW'(picks_r) <= (n_used - NW'(1))) && (picks_r != '0)))
    else $error("round count out of range");

  // results are only launched from the report phase
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the report phase");

endmodule

`default_nettype wire

// ===== bench/tb_prim_spanning_tree_matrix.sv =====
`timescale 1ns / 1ps

module tb_prim_spanning_tree_matrix;

  localparam int NUM_VERTICES = 16;
  localparam int WEIGHT_W     = 16;
  // key value meaning "no edge seen yet": one past the largest weight
  localparam logic [WEIGHT_W:0] KEY_INF = 17'h1_0000;

  localparam int RANDOM_ENTRIES = 160;
  localparam int SETTLE_CYCLES  = 8;    // block may still be storing an entry
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_CYCLES    = 700;  // long enough to outlast a full run

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  pstm_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  pstm_pkg::out_item_t           out_data;
  logic                          cfg_we = 1'b0;
  logic [pstm_pkg::VCOUNT_W-1:0] cfg_wdata = '0;

  // bench copy of the block state: weight matrix and the vertex count register
  logic [WEIGHT_W-1:0]           edge_store [NUM_VERTICES][NUM_VERTICES];
  logic [pstm_pkg::VCOUNT_W-1:0] vertex_count = pstm_pkg::VCOUNT_RESET;

  pstm_pkg::out_item_t pending_edges [$];  // predicted tree edges, oldest first

  int errors = 0;
  int entries_sent = 0;
  int runs_predicted = 0;
  int edges_checked = 0;
  bit [NUM_VERTICES:0] counts_seen = '0;

  bit steady = 1'b0;        // both sides run flat out while set
  bit hold_request = 1'b0;  // asks the result sink for a long stall

  prim_spanning_tree_matrix #(
    .MAX_VERTICES(NUM_VERTICES),
    .WEIGHT_BITS (WEIGHT_W)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Timeout at %0t ns", $time);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prim predictor. Runs from vertex 0 over the effective vertex count;
  // ties go to the lowest-numbered vertex because only a strictly smaller
  // key replaces the current pick. Stops early when the rest of the graph
  // is unreachable; those vertices report parent 0, weight 0, not reached.
  // ---------------------------------------------------------------------
  function automatic void predict_spanning_tree();
    int              n;
    int              best;
    logic [WEIGHT_W:0] low;
    logic [WEIGHT_W:0] key [NUM_VERTICES];
    logic [pstm_pkg::VIDX_W-1:0] parent [NUM_VERTICES];
    bit              joined [NUM_VERTICES];
    logic [pstm_pkg::TOTAL_W-1:0] running;
    pstm_pkg::out_item_t res;
    // register value saturates into 2 .. NUM_VERTICES
    n = (vertex_count < 2) ? 2 :
        (vertex_count > NUM_VERTICES) ? NUM_VERTICES : int'(vertex_count);
    for (int v = 0; v < NUM_VERTICES; v++) begin
      key[v] = KEY_INF;
      parent[v] = '0;
      joined[v] = 1'b0;
    end
    key[0] = '0;
    for (int rnd = 0; rnd + 1 < n; rnd++) begin
      best = n;
      low = KEY_INF;
      for (int v = 0; v < n; v++)
        if (!joined[v] && key[v] < low) begin
          low = key[v];
          best = v;
        end
      if (best >= n) break;
      joined[best] = 1'b1;
      // relax the row of the new tree vertex; zero means no edge
      for (int v = 0; v < n; v++)
        if (edge_store[best][v] != 0 && !joined[v] &&
            {1'b0, edge_store[best][v]} < key[v]) begin
          key[v] = {1'b0, edge_store[best][v]};
          parent[v] = best[pstm_pkg::VIDX_W-1:0];
        end
    end
    running = '0;
    for (int v = 1; v < n; v++) begin
      res.reached       = (key[v] < KEY_INF);
      res.parent_vertex = res.reached ? parent[v] : '0;
      res.child_vertex  = v[pstm_pkg::VIDX_W-1:0];
      res.edge_weight   = res.reached ? key[v][WEIGHT_W-1:0] : '0;
      // wraps at 20 bits
      running           = running + pstm_pkg::TOTAL_W'(res.edge_weight);
      res.total_cost    = running;
      res.last_edge     = (v == n - 1);
      pending_edges.push_back(res);
    end
    runs_predicted++;
    counts_seen[n] = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver. valid stays up across back-to-back requests; a gap
  // drops it once and waits before raising it again. Callers lower valid themselves
  // (via wait_idle) before leaving the input quiet.
  // ---------------------------------------------------------------------
  task automatic send_entry(input pstm_pkg::in_item_t entry);
    if (!steady && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= entry;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: store first, then a last request runs Prim
    edge_store[entry.row][entry.column] = entry.weight;
    entries_sent++;
    if (entry.last) predict_spanning_tree();
  endtask

  task automatic send_edge(input int src, input int dst, input int w, input bit is_last);
    pstm_pkg::in_item_t e;
    e.row    = src[pstm_pkg::VIDX_W-1:0];
    e.column = dst[pstm_pkg::VIDX_W-1:0];
    e.weight = w[WEIGHT_W-1:0];
    e.last   = is_last;
    send_entry(e);
  endtask

  // drop valid, let every predicted edge come out, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [pstm_pkg::VCOUNT_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    vertex_count = value;
  endtask

  // weights biased toward no-edge, the maximum and tiny values (ties)
  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return '0;
    if (pick < 35) return '1;
    if (pick < 45) return WEIGHT_W'($urandom_range(1, 3));
    return WEIGHT_W'($urandom_range(0, 65535));
  endfunction

  function automatic pstm_pkg::in_item_t rand_entry(input int span, input bit is_last);
    pstm_pkg::in_item_t e;
    e.row    = pstm_pkg::VIDX_W'($urandom_range(0, span - 1));
    e.column = pstm_pkg::VIDX_W'($urandom_range(0, span - 1));
    e.weight = rand_weight();
    e.last   = is_last;
    return e;
  endfunction

  // A graph update: a few entries inside the used square, then a request
  // with last set. Noisy bursts hit any cell and may leave last off.
  task automatic send_graph_burst(input int span, input bit noisy);
    int used;
    used = noisy ? NUM_VERTICES : span;
    repeat ($urandom_range(0, 6)) send_entry(rand_entry(used, 1'b0));
    send_entry(rand_entry(used, noisy ? bit'($urandom_range(0, 1)) : 1'b1));
  endtask

  function automatic int effective_count();
    if (vertex_count < 2) return 2;
    if (vertex_count > NUM_VERTICES) return NUM_VERTICES;
    return int'(vertex_count);
  endfunction

  // ---------------------------------------------------------------------
  // Result sink: random stalls, a long hold-off on request, and flat-out
  // acceptance while steady is set.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 9);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // every accepted result against the oldest prediction
  always @(posedge clk) begin : result_check
    pstm_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_edges.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, got %h", $time, out_data);
      end else begin
        want = pending_edges.pop_front();
        check_field("parent_vertex", 32'(want.parent_vertex), 32'(out_data.parent_vertex));
        check_field("child_vertex",  32'(want.child_vertex),  32'(out_data.child_vertex));
        check_field("edge_weight",   32'(want.edge_weight),   32'(out_data.edge_weight));
        check_field("reached",       32'(want.reached),       32'(out_data.reached));
        check_field("total_cost",    32'(want.total_cost),    32'(out_data.total_cost));
        check_field("last_edge",     32'(want.last_edge),     32'(out_data.last_edge));
        edges_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Loads the whole 16x16 matrix at the reset vertex count and runs on the
  // last cell. After this no later run can read an unwritten cell.
  task automatic test_default_count();
    for (int r = 0; r < NUM_VERTICES; r++)
      for (int c = 0; c < NUM_VERTICES; c++)
        send_edge(r, c, rand_weight(), (r == NUM_VERTICES - 1) && (c == NUM_VERTICES - 1));
  endtask

  // two vertices: heaviest edge, then vertex 1 reachable only backwards
  task automatic test_two_vertices();
    write_vertex_count(5'd2);
    send_edge(0, 1, 16'hFFFF, 1'b1);
    send_edge(0, 1, 0, 1'b0);
    send_edge(1, 0, 5, 1'b1);
    send_edge(0, 1, 1, 1'b1);
  endtask

  // register values below 2 and above 16 clamp
  task automatic test_count_saturation();
    write_vertex_count(5'd0);
    send_edge(0, 1, 9, 1'b1);
    write_vertex_count(5'd1);
    send_edge(1, 1, 0, 1'b1);
    write_vertex_count(5'd31);
    send_edge(15, 15, 0, 1'b1);
    write_vertex_count(5'd17);
    send_edge(0, 15, 16'hFFFF, 1'b1);
  endtask

  // Star from vertex 0 with equal weights: picks go 1, 2, 3 by index.
  // Cells outside the 4x4 square must not matter. Then cut vertex 3 off.
  task automatic test_star_ties_and_gaps();
    write_vertex_count(5'd4);
    send_edge(0, 1, 7, 1'b0);
    send_edge(0, 2, 7, 1'b0);
    send_edge(0, 3, 7, 1'b0);
    for (int r = 1; r < 4; r++)
      for (int c = 1; c < 4; c++)
        if (r != c) send_edge(r, c, 0, 1'b0);
    send_edge(9, 2, 1, 1'b0);
    send_edge(2, 9, 1, 1'b1);
    send_edge(0, 3, 0, 1'b1);
  endtask

  // Result side stalls for a long stretch while requests keep coming, so
  // the block stops taking input until the sink drains it.
  task automatic test_output_backpressure();
    write_vertex_count(5'd8);
    hold_request = 1'b1;
    repeat (3) send_graph_burst(8, 1'b0);
    wait_idle();
  endtask

  // no idling on either side
  task automatic test_steady_stream();
    write_vertex_count(5'd16);
    steady = 1'b1;
    repeat (8) send_graph_burst(NUM_VERTICES, 1'b0);
    wait_idle();
    steady = 1'b0;
  endtask

  task automatic test_random_graphs();
    int stop_at;
    stop_at = entries_sent + RANDOM_ENTRIES;
    while (entries_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 7))
          0:       write_vertex_count(5'd2);
          1:       write_vertex_count(5'd16);
          2:       write_vertex_count(pstm_pkg::VCOUNT_W'($urandom_range(0, 1)));
          3:       write_vertex_count(pstm_pkg::VCOUNT_W'($urandom_range(17, 31)));
          default: write_vertex_count(pstm_pkg::VCOUNT_W'($urandom_range(2, 8)));
        endcase
      end
      send_graph_burst(effective_count(), $urandom_range(0, 99) < 15);
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_count();
    test_two_vertices();
    test_count_saturation();
    test_star_ties_and_gaps();
    test_output_backpressure();
    test_steady_stream();
    test_random_graphs();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Loaded %0d matrix entries, ran Prim %0d times, checked %0d tree edges",
             entries_sent, runs_predicted, edges_checked);
    $display("%0d distinct vertex counts used, incl. clamped settings, stalls and hold-off",
             $countones(counts_seen));
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
